[rtl/y2r_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_pkg
// Types, coefficients and the shift-and-clamp helper shared by the
// 4:2:0 block to RGB converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int SampleW = 8;
  localparam int TermW   = 16;  // widest product: (Y-16)*74 fits in 16 signed bits
  localparam int SumW    = 18;  // luma term plus chroma term, with headroom
  localparam int FracBits = 6;
  localparam int QuotW   = SumW - FracBits;

  localparam logic signed [SampleW:0] LUMA_OFFSET   = 9'sd16;
  localparam logic signed [SampleW:0] CHROMA_OFFSET = 9'sd128;

  localparam logic signed [TermW-1:0] COEF_Y  = 16'sd74;
  localparam logic signed [TermW-1:0] COEF_RV = 16'sd102;
  localparam logic signed [TermW-1:0] COEF_GU = 16'sd25;
  localparam logic signed [TermW-1:0] COEF_GV = 16'sd52;
  localparam logic signed [TermW-1:0] COEF_BU = 16'sd129;

  localparam int NumLanes = 4;

  typedef struct packed {
    logic [SampleW-1:0] luma_top_left;
    logic [SampleW-1:0] luma_top_right;
    logic [SampleW-1:0] luma_bottom_left;
    logic [SampleW-1:0] luma_bottom_right;
    logic [SampleW-1:0] chroma_u;
    logic [SampleW-1:0] chroma_v;
  } in_word_t;

  typedef struct packed {
    logic [SampleW-1:0] red_top_left;
    logic [SampleW-1:0] green_top_left;
    logic [SampleW-1:0] blue_top_left;
    logic [SampleW-1:0] red_top_right;
    logic [SampleW-1:0] green_top_right;
    logic [SampleW-1:0] blue_top_right;
    logic [SampleW-1:0] red_bottom_left;
    logic [SampleW-1:0] green_bottom_left;
    logic [SampleW-1:0] blue_bottom_left;
    logic [SampleW-1:0] red_bottom_right;
    logic [SampleW-1:0] green_bottom_right;
    logic [SampleW-1:0] blue_bottom_right;
  } out_word_t;

  // Chroma contributions shared by all four pixels of a block.
  typedef struct packed {
    logic signed [TermW-1:0] red_add;
    logic signed [TermW-1:0] green_sub;
    logic signed [TermW-1:0] blue_add;
  } chroma_terms_t;

  typedef struct packed {
    logic [SampleW-1:0] red;
    logic [SampleW-1:0] green;
    logic [SampleW-1:0] blue;
  } pixel_t;

  // Load enables of the two pipeline stages.
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctl_t;

  // Floor division by 64 followed by a clamp to 0..255.
  function automatic logic [SampleW-1:0] shift_clamp(input logic signed [SumW-1:0] sum);
    logic signed [QuotW-1:0] q;
    logic [SampleW-1:0] res;
    q = QuotW'(sum >>> FracBits);
    if (q < 0) begin
      res = '0;
    end else if (q > $signed(QuotW'(255))) begin
      res = '1;
    end else begin
      res = q[SampleW-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/y2r_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r channel interfaces
// Valid/ready channels for the YUV block input and the RGB pixel output.
// ----------------------------------------------------------------------------
interface y2r_in_if;
  import y2r_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface y2r_out_if;
  import y2r_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/y2r_chroma.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_chroma
// Forms the red, green and blue chroma contributions of one block and
// registers them in the first pipeline stage.
// ----------------------------------------------------------------------------
module y2r_chroma (
  input  logic                     clk,
  input  y2r_pkg::pipe_ctl_t       ctl,
  input  logic [7:0]               chroma_u,
  input  logic [7:0]               chroma_v,
  output y2r_pkg::chroma_terms_t   terms
);
  import y2r_pkg::*;

  logic signed [SampleW:0] du;
  logic signed [SampleW:0] dv;
  chroma_terms_t           terms_next;

  always_comb begin
    du = $signed({1'b0, chroma_u}) - CHROMA_OFFSET;
    dv = $signed({1'b0, chroma_v}) - CHROMA_OFFSET;
    terms_next.red_add   = TermW'(dv) * COEF_RV;
    terms_next.green_sub = TermW'(du) * COEF_GU + TermW'(dv) * COEF_GV;
    terms_next.blue_add  = TermW'(du) * COEF_BU;
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      terms <= terms_next;
    end
  end

endmodule

[rtl/y2r_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y2r_lane
// One pixel lane: scales the luma sample in stage one, then adds the shared
// chroma terms, shifts and clamps into an RGB pixel in stage two.
// ----------------------------------------------------------------------------
module y2r_lane (
  input  logic                     clk,
  input  y2r_pkg::pipe_ctl_t       ctl,
  input  logic [7:0]               luma,
  input  y2r_pkg::chroma_terms_t   terms,
  output y2r_pkg::pixel_t          pixel
);
  import y2r_pkg::*;

  logic signed [SampleW:0]  dy;
  logic signed [TermW-1:0]  luma_term_next;
  logic signed [TermW-1:0]  luma_term;
  logic signed [SumW-1:0]   red_sum;
  logic signed [SumW-1:0]   green_sum;
  logic signed [SumW-1:0]   blue_sum;
  pixel_t                   pixel_next;

  always_comb begin
    dy = $signed({1'b0, luma}) - LUMA_OFFSET;
    luma_term_next = TermW'(dy) * COEF_Y;
  end

  always_comb begin
    red_sum   = SumW'(luma_term) + SumW'(terms.red_add);
    green_sum = SumW'(luma_term) - SumW'(terms.green_sub);
    blue_sum  = SumW'(luma_term) + SumW'(terms.blue_add);
    pixel_next.red   = shift_clamp(red_sum);
    pixel_next.green = shift_clamp(green_sum);
    pixel_next.blue  = shift_clamp(blue_sum);
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      luma_term <= luma_term_next;
    end
    if (ctl.s2_load) begin
      pixel <= pixel_next;
    end
  end

endmodule

[rtl/yuv420_block_to_rgb_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_unit
// Converts one 4:2:0 block (2x2 luma, shared U and V) into four RGB pixels.
// ----------------------------------------------------------------------------
// One block is accepted per clock while the output does not stall; each block's
// four pixels leave in order via the stage-one and output registers. Stage one
// forms the luma products in four parallel lanes and the shared chroma products
// once; stage two adds, shifts and clamps per lane into the output register,
// where the lanes are merged into one output word. A stalled output holds the
// pipeline; the input is ready whenever stage one is empty or can move on.
module yuv420_block_to_rgb_unit (
  input  logic               clk,
  input  logic               rst,
  y2r_in_if.sink             blk,
  y2r_out_if.source          rgb
);
  import y2r_pkg::*;

  logic          s1_valid;
  logic          s2_valid;
  logic          s2_move;
  logic          s1_move;
  pipe_ctl_t     ctl;
  chroma_terms_t terms;
  pixel_t        pix [NumLanes];
  logic [7:0]    luma [NumLanes];

  assign s2_move = !s2_valid || rgb.ready;
  assign s1_move = !s1_valid || s2_move;
  assign blk.ready = s1_move;
  assign ctl.s1_load = blk.valid && s1_move;
  assign ctl.s2_load = s1_valid && s2_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_move) begin
        s1_valid <= blk.valid;
      end
      if (s2_move) begin
        s2_valid <= s1_valid;
      end
    end
  end

  assign luma[0] = blk.data.luma_top_left;
  assign luma[1] = blk.data.luma_top_right;
  assign luma[2] = blk.data.luma_bottom_left;
  assign luma[3] = blk.data.luma_bottom_right;

  y2r_chroma u_chroma (
    .clk      (clk),
    .ctl      (ctl),
    .chroma_u (blk.data.chroma_u),
    .chroma_v (blk.data.chroma_v),
    .terms    (terms)
  );

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    y2r_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .luma  (luma[i]),
      .terms (terms),
      .pixel (pix[i])
    );
  end

  // Merge the lane results into the output word.
  assign rgb.valid = s2_valid;
  assign rgb.data.red_top_left       = pix[0].red;
  assign rgb.data.green_top_left     = pix[0].green;
  assign rgb.data.blue_top_left      = pix[0].blue;
  assign rgb.data.red_top_right      = pix[1].red;
  assign rgb.data.green_top_right    = pix[1].green;
  assign rgb.data.blue_top_right     = pix[1].blue;
  assign rgb.data.red_bottom_left    = pix[2].red;
  assign rgb.data.green_bottom_left  = pix[2].green;
  assign rgb.data.blue_bottom_left   = pix[2].blue;
  assign rgb.data.red_bottom_right   = pix[3].red;
  assign rgb.data.green_bottom_right = pix[3].green;
  assign rgb.data.blue_bottom_right  = pix[3].blue;

  // An accepted word always occupies stage one on the next cycle.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    blk.valid && blk.ready |=> s1_valid)
    else $error("accepted word did not reach stage one");

  // A word in stage one is never dropped while the output stalls.
  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_move |=> s1_valid)
    else $error("stage one word lost during stall");

  // A word moving out of stage one always lands in the output register.
  a_s1_to_s2: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_move |=> s2_valid)
    else $error("stage one word not transferred to output");

  // No output word appears without one in stage one.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !s1_valid && s2_move |=> !s2_valid)
    else $error("output word appeared from an empty pipeline");

endmodule
